/* rtl/rms_current_meter_unit_defines.svh */
// assertion helpers shared by the rtl files
`ifndef RMS_CURRENT_METER_UNIT_DEFINES_SVH
`define RMS_CURRENT_METER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RCM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define RCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rcm_pkg;

	// fixed widths of the state and the result fields
	localparam int SUM_W    = 30;
	localparam int COUNT_W  = 11;
	localparam int ZERO_W   = 10;
	localparam int GAIN_W   = 16;
	localparam int CFG_W    = 16;
	localparam int CUR_W    = 16;
	localparam int RMS_W    = 18;
	localparam int ROOT_W   = 24;
	localparam int RAD_W    = 2 * ROOT_W;
	localparam int SREM_W   = ROOT_W + 2;
	localparam int PROD_W   = ROOT_W + GAIN_W;
	localparam int WIN_W    = 13;

	// iteration counts of the shared units
	localparam int DIV_STEPS  = SUM_W;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int ITER_W     = 5;

	// register reset values
	localparam logic [ZERO_W-1:0]  ZERO_OFFSET_RST   = 10'd532;
	localparam logic [COUNT_W-1:0] WINDOW_LENGTH_RST = 11'd100;
	localparam logic [GAIN_W-1:0]  GAIN_RST          = 16'd6756;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 2'd2;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_DIV,
		ST_PREP,
		ST_SQRT,
		ST_MUL,
		ST_OUT
	} rcm_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic acc_en;
		logic load;
		logic div_step;
		logic sqrt_load;
		logic sqrt_step;
		logic mul_en;
		logic out_load;
	} rcm_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic close;
	} rcm_stat_t;

endpackage

`default_nettype wire

/* rtl/rcm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "rms_current_meter_unit_defines.svh"

module rcm_ctrl
	import rcm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire rcm_stat_t stat,
	output rcm_cmd_t       cmd
);

	rcm_state_t state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic out_valid_q;
	logic div_last, sqrt_last, out_free;

	assign div_last  = (iter_q == ITER_W'(DIV_STEPS - 1));
	assign sqrt_last = (iter_q == ITER_W'(SQRT_STEPS - 1));
	assign out_free  = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACC: begin
				if (s_tvalid && stat.close)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last)
					state_d = ST_PREP;
			end
			ST_PREP: state_d = ST_SQRT;
			ST_SQRT: begin
				if (sqrt_last)
					state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_d = ST_ACC;
			end
			default: state_d = ST_ACC;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_ACC: begin
				s_tready = 1'b1;
				cmd.acc_en = s_tvalid;
				cmd.load = s_tvalid && stat.close;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_PREP: cmd.sqrt_load = 1'b1;
			ST_SQRT: cmd.sqrt_step = 1'b1;
			ST_MUL:  cmd.mul_en = 1'b1;
			ST_OUT:  cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	// state, iteration counter and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			iter_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_DIV && !div_last) || (state_q == ST_SQRT && !sqrt_last))
				iter_q <= iter_q + ITER_W'(1);
			else
				iter_q <= '0;
			out_valid_q <= cmd.out_load || (out_valid_q && !m_tready);
		end
	end

	assign m_tvalid = out_valid_q;

	`RCM_ASSERT_IMPL(a_no_overwrite, cmd.out_load && out_valid_q, m_tready, "result overwritten before transfer")
	`RCM_ASSERT_NEXT(a_close_starts_div, s_tvalid && s_tready && stat.close, state_q == ST_DIV, "closing sample did not start the divide")
	`RCM_ASSERT_NEXT(a_div_length, state_q == ST_DIV && div_last, state_q == ST_PREP && iter_q == '0, "divide did not end after its steps")

endmodule

`default_nettype wire

/* rtl/rcm_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "rms_current_meter_unit_defines.svh"

module rcm_dpath
	import rcm_pkg::*;
#(
	parameter int SAMPLE_BITS = 10,
	parameter int MAX_WINDOW  = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_wdata,
	input  wire rcm_cmd_t               cmd,
	output rcm_stat_t                   stat,
	output logic [CUR_W-1:0]            current_ma,
	output logic [RMS_W-1:0]            rms_counts
);

	localparam logic [WIN_W-1:0] MAX_WIN_C = WIN_W'(MAX_WINDOW);

	logic [ZERO_W-1:0]  zero_q;
	logic [COUNT_W-1:0] wlen_q;
	logic [GAIN_W-1:0]  gain_q;

	logic [SUM_W-1:0]   sum_q, sum_next;
	logic [COUNT_W-1:0] count_q, count_next;
	logic [SAMPLE_BITS-1:0] z, mag;
	logic [2*SAMPLE_BITS-1:0] sq;
	logic [WIN_W-1:0] wl_ext, win;

	logic [SUM_W-1:0]   dvd_q;
	logic [COUNT_W-1:0] dvs_q, drem_q;
	logic [COUNT_W:0]   dtrial;
	logic               dfit;

	logic [RAD_W-1:0]  rad_q;
	logic [SREM_W-1:0] srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SREM_W+1:0] sacc, strial;
	logic              sfit;

	logic [PROD_W-1:0] prod_q;
	logic [CUR_W-1:0]  cur_q;
	logic [RMS_W-1:0]  rms_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= ZERO_OFFSET_RST;
			wlen_q <= WINDOW_LENGTH_RST;
			gain_q <= GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZERO_OFFSET:   zero_q <= cfg_wdata[ZERO_W-1:0];
				REG_WINDOW_LENGTH: wlen_q <= cfg_wdata[COUNT_W-1:0];
				REG_GAIN:          gain_q <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// offset correction and square
	assign z = SAMPLE_BITS'(zero_q);
	assign mag = (sample >= z) ? (sample - z) : (z - sample);
	assign sq = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
	assign sum_next = sum_q + SUM_W'(sq);
	assign count_next = count_q + COUNT_W'(1);

	// effective window: zero means one, clamp at the maximum
	assign wl_ext = WIN_W'(wlen_q);
	always_comb begin
		if (wl_ext == '0)
			win = WIN_W'(1);
		else if (wl_ext > MAX_WIN_C)
			win = MAX_WIN_C;
		else
			win = wl_ext;
	end
	assign stat.close = (WIN_W'(count_next) >= win);

	// window accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
		end else if (cmd.load) begin
			sum_q <= '0;
			count_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q <= sum_next;
			count_q <= count_next;
		end
	end

	// restoring divider, one quotient bit per step
	assign dtrial = {drem_q, dvd_q[SUM_W-1]};
	assign dfit = (dtrial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q <= sum_next;
			dvs_q <= count_next;
			drem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[SUM_W-2:0], dfit};
			drem_q <= dfit ? COUNT_W'(dtrial - {1'b0, dvs_q}) : dtrial[COUNT_W-1:0];
		end
	end

	// digit-by-digit square root, two radicand bits per step
	assign sacc = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sfit = (sacc >= strial);

	always_ff @(posedge clk) begin
		if (cmd.sqrt_load) begin
			rad_q <= {2'b00, dvd_q, 16'h0000};
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			srem_q <= sfit ? SREM_W'(sacc - strial) : SREM_W'(sacc);
			root_q <= {root_q[ROOT_W-2:0], sfit};
		end
	end

	// gain scaling and result register
	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= PROD_W'(root_q) * PROD_W'(gain_q);
		if (cmd.out_load) begin
			cur_q <= (|prod_q[PROD_W-1:2*CUR_W]) ? {CUR_W{1'b1}} : prod_q[2*CUR_W-1:CUR_W];
			rms_q <= root_q[RMS_W-1:0];
		end
	end

	assign current_ma = cur_q;
	assign rms_counts = rms_q;

	`RCM_ASSERT_IMPL(a_divisor_nonzero, cmd.load, count_next != '0, "window closed with zero count")
	`RCM_ASSERT_NEXT(a_window_cleared, cmd.load, sum_q == '0 && count_q == '0, "window state not cleared")

endmodule

`default_nettype wire

/* rtl/rms_current_meter_unit.sv */
// rms current meter
// input stream: one ADC sample per transfer, s_tdata low SAMPLE_BITS bits.
// each sample has the zero offset removed and its square added to the
// window sum; a transfer is accepted whenever the meter is collecting.
// the sample that completes the window starts the result: a 30-step
// restoring divide (sum by count), root setup, a 24-step square root, gain
// multiply and the output register load, during which s_tready is low.
// output stream: one result per window, held in an output register until
// transferred; collection of the next window goes on while it waits, and a
// new result waits in the controller, with s_tready low, until the register
// is free.
// configuration: cfg_we writes cfg_wdata to register cfg_index (0 zero
// offset, 1 window length, 2 gain); write only while the meter is idle.
// reset clears the window sum and count, empties the output register and
// loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module rms_current_meter_unit
	import rcm_pkg::*;
#(
	parameter int SAMPLE_BITS = 10,
	parameter int MAX_WINDOW  = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// sample (bits SAMPLE_BITS-1:0), zero fill above
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// current_ma (15:0), rms_counts (33:16), zero fill above
	output logic [39:0]                    m_tdata,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_W-1:0]          cfg_wdata
);

	rcm_cmd_t  cmd;
	rcm_stat_t stat;
	logic [CUR_W-1:0] current_ma;
	logic [RMS_W-1:0] rms_counts;

	rcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rcm_dpath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_WINDOW  (MAX_WINDOW)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (s_tdata[SAMPLE_BITS-1:0]),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.stat       (stat),
		.current_ma (current_ma),
		.rms_counts (rms_counts)
	);

	// pack result fields, lowest first
	assign m_tdata = {6'b000000, rms_counts, current_ma};

endmodule

`default_nettype wire
